FILE: hdl/cfrt_pkg.sv
// Shared constants, state type and control struct for the complex FIR with real taps.
`default_nettype none

package cfrt_pkg;

    // Filter dimensions
    localparam int MAX_TAPS     = 128;
    localparam int SAMPLE_WIDTH = 16;

    // Fixed field widths
    localparam int COEF_W      = 16;
    localparam int TAP_INDEX_W = 7;
    localparam int TAP_COUNT_W = 8;

    // Derived sizes
    localparam int HIST_LEN  = MAX_TAPS - 1;
    localparam int HIST_AW   = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int COEF_AW   = $clog2(MAX_TAPS);
    localparam int K_W       = $clog2(MAX_TAPS + 1);
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC_BITS = COEF_W - 1;

    // Stream packing
    localparam int IN_OFS_Q     = SAMPLE_WIDTH;
    localparam int IN_OFS_IDX   = 2 * SAMPLE_WIDTH;
    localparam int IN_OFS_VAL   = 2 * SAMPLE_WIDTH + TAP_INDEX_W;
    localparam int IN_FIELDS_W  = 2 * SAMPLE_WIDTH + TAP_INDEX_W + COEF_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    // Item kinds carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fir_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/complex_fir_real_taps.sv
// Top level: direct-form complex I/Q FIR with real Q1.15 taps, one shared MAC.
`default_nettype none

// Direct-form FIR on complex I/Q samples with real Q1.15 coefficients. Each
// sample item (tuser = 0) yields one result: the sum of tap[k] * x[n-k] over
// k < tap_count, for I and Q separately, rounded half-up at 2^15 and
// saturated to 16 bits. A coefficient item (tuser = 1) writes one tap and
// yields no result. tap_count of zero passes the sample through unchanged;
// values above MAX_TAPS act as MAX_TAPS. Every sample enters the history
// regardless of tap_count; the history starts all zero. Taps must be written
// before they are used. Each sample item runs one multiply-accumulate per tap
// on a single shared I/Q MAC unit fed from the tap and history memories. The
// block takes no new item until the result (or, in bypass, the sample) enters
// the output register, which may wait for it to drain. A coefficient item
// leaves the block idle. tap_count may change only while the block is idle.
module complex_fir_real_taps (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tap_count register write
    input  logic                                  cfg_wr_en,
    input  logic [cfrt_pkg::TAP_COUNT_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: sample_i, sample_q, tap_index, tap_value (low to high), zero pad
    input  logic [cfrt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser: command
    input  logic                                  s_axis_tuser,
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: out_i, out_q (low to high)
    output logic [cfrt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import cfrt_pkg::*;

    // unpacked input fields
    logic signed [SAMPLE_WIDTH-1:0] in_samp_i;
    logic signed [SAMPLE_WIDTH-1:0] in_samp_q;
    logic [TAP_INDEX_W-1:0]         in_tap_index;
    logic signed [COEF_W-1:0]       in_tap_value;

    // config
    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [K_W-1:0]         taps_clamped;

    // sequencer
    fir_state_t          state_reg, state_next;
    logic [K_W-1:0]      taps_reg, taps_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [HIST_AW-1:0]  pos_reg, pos_next;
    logic [HIST_AW-1:0]  ptr_reg, ptr_next;
    logic                bypass_reg, bypass_next;
    logic signed [SAMPLE_WIDTH-1:0] samp_i_reg;
    logic signed [SAMPLE_WIDTH-1:0] samp_q_reg;

    logic in_accept;
    logic in_sample;
    logic in_coef;
    logic issue;
    logic last_tap;
    logic load_out;
    mac_ctl_t mac_ctl;

    // memories
    logic signed [COEF_W-1:0]       coef_mem [MAX_TAPS];
    logic [2*SAMPLE_WIDTH-1:0]      hist_mem [HIST_LEN];
    logic [HIST_LEN-1:0]            hist_vld_reg;

    // read stage
    logic signed [COEF_W-1:0]       coef_rd_reg;
    logic [2*SAMPLE_WIDTH-1:0]      hist_rd_reg;
    logic                           hist_vld_rd_reg;
    logic                           use_x0_reg;
    logic                           vld1_reg;
    logic signed [SAMPLE_WIDTH-1:0] op_i;
    logic signed [SAMPLE_WIDTH-1:0] op_q;

    // MAC
    logic                           mac_busy;
    logic signed [SAMPLE_WIDTH-1:0] mac_res_i;
    logic signed [SAMPLE_WIDTH-1:0] mac_res_q;

    // output register
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_i_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_q_reg;

    assign in_samp_i    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_samp_q    = s_axis_tdata[IN_OFS_Q+SAMPLE_WIDTH-1:IN_OFS_Q];
    assign in_tap_index = s_axis_tdata[IN_OFS_IDX+TAP_INDEX_W-1:IN_OFS_IDX];
    assign in_tap_value = s_axis_tdata[IN_OFS_VAL+COEF_W-1:IN_OFS_VAL];

    assign taps_clamped = (32'(tap_count_reg) > MAX_TAPS) ? K_W'(MAX_TAPS)
                                                         : K_W'(tap_count_reg);

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_sample = in_accept && (s_axis_tuser == CMD_SAMPLE);
    assign in_coef   = in_accept && (s_axis_tuser == CMD_COEF);
    assign last_tap  = issue && (k_reg == (taps_reg - K_W'(1)));

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_sample)
                    state_next = (taps_clamped == '0) ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!vld1_reg && !mac_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_RUN:   issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  load_out = !out_valid_reg || m_axis_tready;
            default:  ;
        endcase
        mac_ctl.clear = in_sample;
        mac_ctl.valid = vld1_reg;
    end

    // ---------------- counters and pointers ----------------
    always_comb
    begin
        taps_next   = taps_reg;
        bypass_next = bypass_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        if (in_sample)
        begin
            taps_next   = taps_clamped;
            bypass_next = (taps_clamped == '0);
            k_next      = '0;
            // x[n-1] sits one slot behind the write pointer
            pos_next    = (ptr_reg == '0) ? HIST_AW'(HIST_LEN - 1) : ptr_reg - HIST_AW'(1);
        end
        else if (issue)
        begin
            k_next = k_reg + K_W'(1);
            // tap 0 uses the live sample, history walk starts at tap 1
            if (k_reg != '0)
                pos_next = (pos_reg == '0) ? HIST_AW'(HIST_LEN - 1) : pos_reg - HIST_AW'(1);
        end
        if (load_out)
            ptr_next = (32'(ptr_reg) == HIST_LEN - 1) ? '0 : ptr_reg + HIST_AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= '0;
            taps_reg      <= '0;
            bypass_reg    <= 1'b0;
            k_reg         <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            hist_vld_reg  <= '0;
            vld1_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            taps_reg   <= taps_next;
            bypass_reg <= bypass_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
            ptr_reg    <= ptr_next;
            vld1_reg   <= issue;
            if (cfg_wr_en)
                tap_count_reg <= cfg_wr_data;
            if (load_out)
                hist_vld_reg[ptr_reg] <= 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- memories and read stage ----------------
    always_ff @(posedge clk)
    begin
        if (in_coef && (32'(in_tap_index) < MAX_TAPS))
            coef_mem[COEF_AW'(in_tap_index)] <= in_tap_value;
        if (load_out)
            hist_mem[ptr_reg] <= {samp_q_reg, samp_i_reg};
        coef_rd_reg     <= coef_mem[k_reg[COEF_AW-1:0]];
        hist_rd_reg     <= hist_mem[pos_reg];
        hist_vld_rd_reg <= hist_vld_reg[pos_reg];
        use_x0_reg      <= (k_reg == '0);
    end

    // sample payload and result register
    always_ff @(posedge clk)
    begin
        if (in_sample)
        begin
            samp_i_reg <= in_samp_i;
            samp_q_reg <= in_samp_q;
        end
        if (load_out)
        begin
            out_i_reg <= bypass_reg ? samp_i_reg : mac_res_i;
            out_q_reg <= bypass_reg ? samp_q_reg : mac_res_q;
        end
    end

    // never-written history slots read as zero
    always_comb
    begin
        if (use_x0_reg)
        begin
            op_i = samp_i_reg;
            op_q = samp_q_reg;
        end
        else if (hist_vld_rd_reg)
        begin
            op_i = hist_rd_reg[SAMPLE_WIDTH-1:0];
            op_q = hist_rd_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
        else
        begin
            op_i = '0;
            op_q = '0;
        end
    end

    cfrt_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .x_i   (op_i),
        .x_q   (op_q),
        .coef  (coef_rd_reg),
        .busy  (mac_busy),
        .res_i (mac_res_i),
        .res_q (mac_res_q)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_q_reg, out_i_reg});

    // ---------------- assertions ----------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!vld1_reg && !mac_busy))
        else $error("MAC pipeline busy while idle");

    a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!vld1_reg && !mac_busy))
        else $error("result taken before accumulation finished");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg < taps_reg))
        else $error("tap counter ran past tap count");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_sample |=> (state_reg != ST_IDLE))
        else $error("sample item did not start processing");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ptr_reg) < HIST_LEN) && (32'(pos_reg) < HIST_LEN))
        else $error("history pointer out of range");

endmodule

`default_nettype wire

FILE: hdl/cfrt_mac.sv
// Shared I/Q multiply-accumulate unit with round-half-up and saturation.
`default_nettype none

module cfrt_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cfrt_pkg::mac_ctl_t                       ctl,
    input  logic signed [cfrt_pkg::SAMPLE_WIDTH-1:0] x_i,
    input  logic signed [cfrt_pkg::SAMPLE_WIDTH-1:0] x_q,
    input  logic signed [cfrt_pkg::COEF_W-1:0]       coef,
    output logic                                     busy,
    output logic signed [cfrt_pkg::SAMPLE_WIDTH-1:0] res_i,
    output logic signed [cfrt_pkg::SAMPLE_WIDTH-1:0] res_q
);
    import cfrt_pkg::*;

    localparam int SUM_W      = ACC_W + 1;
    localparam int WHOLE_W    = SUM_W - FRAC_BITS;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_q_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_i_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;

    // add half an LSB, drop fraction, clamp to sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic [SUM_W-1:0]   sum;
        logic [WHOLE_W-1:0] whole;
        logic [WHOLE_W-SAMPLE_WIDTH:0] top;
        sum   = {acc[ACC_W-1], acc} + SUM_W'(ROUND_HALF);
        whole = sum[SUM_W-1:FRAC_BITS];
        top   = whole[WHOLE_W-1:SAMPLE_WIDTH-1];
        if ((&top) || !(|top))
            round_sat = whole[SAMPLE_WIDTH-1:0];
        else if (whole[WHOLE_W-1])
            round_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            round_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_i_reg <= x_i * coef;
        prod_q_reg <= x_q * coef;
        if (ctl.clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_i_reg <= acc_i_reg + {{(ACC_W-PROD_W){prod_i_reg[PROD_W-1]}}, prod_i_reg};
            acc_q_reg <= acc_q_reg + {{(ACC_W-PROD_W){prod_q_reg[PROD_W-1]}}, prod_q_reg};
        end
    end

    assign busy  = prod_vld_reg;
    assign res_i = round_sat(acc_i_reg);
    assign res_q = round_sat(acc_q_reg);

endmodule

`default_nettype wire
